>>> rtl/core/grid_vertex_normal_top_defines.svh
// assertion helpers for the vertex normal block, clocked on clk and held off during reset
`ifndef GRID_VERTEX_NORMAL_TOP_DEFINES_SVH
`define GRID_VERTEX_NORMAL_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GVN_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gvn check failed");

// antecedent implies consequent in the next cycle
`define GVN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gvn check failed");

`endif

>>> rtl/core/gvn_pkg.sv
package gvn_pkg;

	// coordinate and point layout
	localparam int CW = 16;
	localparam int PTW = 48;
	localparam int TW = 48;
	// datapath widths
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int BIG_BIT = 24;
	localparam int SQPW = 2 * BIG_BIT;
	localparam int SQLW = SQPW + 2;
	localparam int SUMW = XW + 2;
	localparam int PSW = $clog2(SUMW);
	localparam int NORM_MSB = 29;
	localparam int NW = NORM_MSB + 1;
	localparam int SQW = 2 * NW + 2;
	localparam int RW = SQW / 2;
	localparam int NFB = 14;
	localparam int OW = 16;
	localparam int QW = NFB + 2;
	localparam int DVW = RW + QW - 1;

	// data that rides along the length and divide pipelines
	typedef struct packed {
		logic [2:0][NW-1:0] mag;
		logic [2:0]         neg;
		logic               degen;
	} side_t;

	// signed component pos of a packed point (0 = z, 2 = x)
	function automatic logic signed [CW-1:0] coord_of(input logic [PTW-1:0] w, input int pos);
		logic signed [CW-1:0] c;
		c = w[pos*CW +: CW];
		return c;
	endfunction

endpackage

>>> rtl/core/gvn_lane.sv
module gvn_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic [gvn_pkg::PTW-1:0]       center,
	input  logic [gvn_pkg::PTW-1:0]       pa,
	input  logic [gvn_pkg::PTW-1:0]       pb,
	input  logic [gvn_pkg::TW-1:0]        min_cross_sq,
	output logic [2:0][gvn_pkg::XW-1:0]   contrib
);
	import gvn_pkg::*;

	logic signed [DW-1:0] a_s1 [3];
	logic signed [DW-1:0] b_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [XW-1:0] x_s3 [3];
	logic signed [XW-1:0] x_s4 [3];
	logic [2:0]           big_s4;
	logic [SQPW-1:0]      sqp_s4 [3];
	logic [2:0][XW-1:0]   contrib_s5;

	logic [XW-1:0]   t_mag [3];
	logic [SQLW-1:0] sq_sum;
	logic            take;
	logic            flip;

	// edge vectors from the center
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= DW'(coord_of(pa, 2 - k)) - DW'(coord_of(center, 2 - k));
				b_s1[k] <= DW'(coord_of(pb, 2 - k)) - DW'(coord_of(center, 2 - k));
			end
		end
	end

	// cross product partial products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= a_s1[1] * b_s1[2];
			p_s2[1] <= a_s1[2] * b_s1[1];
			p_s2[2] <= a_s1[2] * b_s1[0];
			p_s2[3] <= a_s1[0] * b_s1[2];
			p_s2[4] <= a_s1[0] * b_s1[1];
			p_s2[5] <= a_s1[1] * b_s1[0];
		end
	end

	// cross product components
	always_ff @(posedge clk) begin
		if (en) begin
			x_s3[0] <= XW'(p_s2[0]) - XW'(p_s2[1]);
			x_s3[1] <= XW'(p_s2[2]) - XW'(p_s2[3]);
			x_s3[2] <= XW'(p_s2[4]) - XW'(p_s2[5]);
		end
	end

	// component magnitudes, large flag and squares
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t_mag[k] = x_s3[k][XW-1] ? XW'(-x_s3[k]) : XW'(x_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				big_s4[k] <= |t_mag[k][XW-1:BIG_BIT];
				sqp_s4[k] <= t_mag[k][BIG_BIT-1:0] * t_mag[k][BIG_BIT-1:0];
				x_s4[k]   <= x_s3[k];
			end
		end
	end

	// threshold test and upward flip
	always_comb begin
		sq_sum = SQLW'(sqp_s4[0]) + SQLW'(sqp_s4[1]) + SQLW'(sqp_s4[2]);
		take   = (|big_s4) || (sq_sum > SQLW'(min_cross_sq));
		flip   = x_s4[1][XW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (!take) begin
					contrib_s5[k] <= '0;
				end else if (flip) begin
					contrib_s5[k] <= XW'(-x_s4[k]);
				end else begin
					contrib_s5[k] <= XW'(x_s4[k]);
				end
			end
		end
	end

	assign contrib = contrib_s5;

endmodule

>>> rtl/core/gvn_sqrt.sv
module gvn_sqrt (
	input  logic                     clk,
	input  logic                     en,
	input  logic [gvn_pkg::SQW-1:0]  sq,
	input  gvn_pkg::side_t           side_in,
	output logic [gvn_pkg::RW-1:0]   root,
	output gvn_pkg::side_t           side_out
);
	import gvn_pkg::*;

	logic [SQW-1:0] rem_s  [RW];
	logic [RW-1:0]  root_s [RW+1];
	side_t          side_s [RW+1];

	assign rem_s[0]  = sq;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	// one root bit per stage, most significant first
	for (genvar s = 0; s < RW; s++) begin : g_step
		localparam int B = RW - 1 - s;
		logic [SQW-1:0] trial;
		logic           fits;

		assign trial = (SQW'(root_s[s]) << (B + 1)) + (SQW'(1) << (2 * B));
		assign fits  = rem_s[s] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[s+1] <= fits ? (root_s[s] | (RW'(1) << B)) : root_s[s];
				side_s[s+1] <= side_s[s];
			end
		end

		if (s < RW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[s+1] <= fits ? (rem_s[s] - trial) : rem_s[s];
				end
			end
		end
	end

	assign root     = root_s[RW];
	assign side_out = side_s[RW];

endmodule

>>> rtl/core/gvn_div.sv
module gvn_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [gvn_pkg::RW-1:0]        root,
	input  gvn_pkg::side_t                side_in,
	output logic [2:0][gvn_pkg::QW-1:0]   quot,
	output gvn_pkg::side_t                side_out
);
	import gvn_pkg::*;

	logic [2:0][DVW-1:0] rem_s  [QW];
	logic [2:0][QW-1:0]  q_s    [QW+1];
	logic [RW-1:0]       len_s  [QW+1];
	side_t               side_s [QW+1];

	// rounded numerators: mag scaled up plus half the length
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rem_s[0][k] = (DVW'(side_in.mag[k]) << NFB) + DVW'(root >> 1);
		end
	end
	assign q_s[0]    = '0;
	assign len_s[0]  = root;
	assign side_s[0] = side_in;

	// one quotient bit per stage across three component lanes
	for (genvar s = 0; s < QW; s++) begin : g_step
		localparam int B = QW - 1 - s;
		logic [DVW-1:0] dsh;
		logic [2:0]     fits;

		assign dsh = DVW'(len_s[s]) << B;
		always_comb begin
			for (int k = 0; k < 3; k++) begin
				fits[k] = rem_s[s][k] >= dsh;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					q_s[s+1][k] <= fits[k] ? (q_s[s][k] | (QW'(1) << B)) : q_s[s][k];
				end
				len_s[s+1]  <= len_s[s];
				side_s[s+1] <= side_s[s];
			end
		end

		if (s < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					for (int k = 0; k < 3; k++) begin
						rem_s[s+1][k] <= fits[k] ? (rem_s[s][k] - dsh) : rem_s[s][k];
					end
				end
			end
		end
	end

	assign quot     = q_s[QW];
	assign side_out = side_s[QW];

endmodule

>>> rtl/core/grid_vertex_normal_top.sv
// channel   direction  handshake             payload
// input     in         in_valid / in_ready   center_point, four neighbor points
// output    out        out_valid / out_ready normal_x, normal_y, normal_z, degenerate
// config    in         cfg_wr_en             cfg_wr_data (min_cross_sq)
//
// one vertex per cycle sustained while the output is not stalled; from input to output register
// a vertex passes 5 lane stages, 7 merge and normalize stages, 31 square root stages, 16 divide
// stages and 1 output register, set by the bit-per-stage root and divide pipelines
// a stalled output freezes the whole pipeline; bubbles are not squeezed out
// reset clears the valid bits and the threshold register
module grid_vertex_normal_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gvn_pkg::PTW-1:0]       center_point,
	input  logic [gvn_pkg::PTW-1:0]       next_slice_point,
	input  logic [gvn_pkg::PTW-1:0]       before_point,
	input  logic [gvn_pkg::PTW-1:0]       prev_slice_point,
	input  logic [gvn_pkg::PTW-1:0]       after_point,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [gvn_pkg::OW-1:0] normal_x,
	output logic signed [gvn_pkg::OW-1:0] normal_y,
	output logic signed [gvn_pkg::OW-1:0] normal_z,
	output logic                          degenerate,
	input  logic                          cfg_wr_en,
	input  logic [gvn_pkg::TW-1:0]        cfg_wr_data
);
	import gvn_pkg::*;

	localparam int LAT = 5 + 7 + RW + QW;

	logic                en;
	logic [LAT-1:0]      vld_q;
	logic                out_valid_q;
	logic [TW-1:0]       min_cross_sq_q;
	logic [PTW-1:0]      nb [4];
	logic [2:0][XW-1:0]  contrib [4];

	logic signed [SUMW-1:0] sum_m1 [3];
	logic [SUMW-1:0]        mag_m2 [3];
	logic [2:0]             neg_m2;
	logic [SUMW-1:0]        mag_m3 [3];
	logic [2:0]             neg_m3;
	logic [SUMW-1:0]        mx_m3;
	logic [SUMW-1:0]        mag_m4 [3];
	logic [2:0]             neg_m4;
	logic [PSW-1:0]         pos_m4;
	logic                   zero_m4;
	logic [NW-1:0]          nmag_m5 [3];
	logic [2:0]             neg_m5;
	logic                   zero_m5;
	logic [2*NW-1:0]        sqr_m6 [3];
	side_t                  side_m6;
	logic [SQW-1:0]         sq_m7;
	side_t                  side_m7;

	logic [SUMW-1:0]        mx;
	logic [PSW-1:0]         pos;
	logic [NW-1:0]          nmag [3];
	logic [RW-1:0]          root;
	side_t                  side_rt;
	logic [2:0][QW-1:0]     quot;
	side_t                  side_dv;

	logic signed [OW-1:0]   nx_q, ny_q, nz_q;
	logic                   degen_q;

	// global advance: move when the output register is free or being drained
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LAT-2:0], in_valid};
			out_valid_q <= vld_q[LAT-1];
		end
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cross_sq_q <= '0;
		end else if (cfg_wr_en) begin
			min_cross_sq_q <= cfg_wr_data;
		end
	end

	// four corner lanes, neighbor ring order
	assign nb[0] = next_slice_point;
	assign nb[1] = before_point;
	assign nb[2] = prev_slice_point;
	assign nb[3] = after_point;

	for (genvar j = 0; j < 4; j++) begin : g_lane
		gvn_lane u_lane (
			.clk          (clk),
			.en           (en),
			.center       (center_point),
			.pa           (nb[j]),
			.pb           (nb[(j + 1) % 4]),
			.min_cross_sq (min_cross_sq_q),
			.contrib      (contrib[j])
		);
	end

	// merge: sum the lane contributions
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sum_m1[k] <= SUMW'($signed(contrib[0][k])) + SUMW'($signed(contrib[1][k]))
					+ SUMW'($signed(contrib[2][k])) + SUMW'($signed(contrib[3][k]));
			end
		end
	end

	// magnitude and sign
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				neg_m2[k] <= sum_m1[k][SUMW-1];
				mag_m2[k] <= sum_m1[k][SUMW-1] ? SUMW'(-sum_m1[k]) : SUMW'(sum_m1[k]);
			end
		end
	end

	// largest magnitude
	always_comb begin
		mx = mag_m2[0];
		if (mag_m2[1] > mx) mx = mag_m2[1];
		if (mag_m2[2] > mx) mx = mag_m2[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_m3 <= mag_m2;
			neg_m3 <= neg_m2;
			mx_m3  <= mx;
		end
	end

	// leading one position of the largest magnitude
	always_comb begin
		pos = '0;
		for (int i = 0; i < SUMW; i++) begin
			if (mx_m3[i]) pos = PSW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_m4  <= mag_m3;
			neg_m4  <= neg_m3;
			pos_m4  <= pos;
			zero_m4 <= (mx_m3 == '0);
		end
	end

	// shift all magnitudes so the largest leads at the normalize bit
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (pos_m4 >= PSW'(NORM_MSB)) begin
				nmag[k] = NW'(mag_m4[k] >> (pos_m4 - PSW'(NORM_MSB)));
			end else begin
				nmag[k] = NW'((NW'(mag_m4[k])) << (PSW'(NORM_MSB) - pos_m4));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_m5 <= nmag;
			neg_m5  <= neg_m4;
			zero_m5 <= zero_m4;
		end
	end

	// squares of the normalized magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sqr_m6[k]         <= nmag_m5[k] * nmag_m5[k];
				side_m6.mag[k]    <= nmag_m5[k];
			end
			side_m6.neg   <= neg_m5;
			side_m6.degen <= zero_m5;
		end
	end

	// squared length
	always_ff @(posedge clk) begin
		if (en) begin
			sq_m7   <= SQW'(sqr_m6[0]) + SQW'(sqr_m6[1]) + SQW'(sqr_m6[2]);
			side_m7 <= side_m6;
		end
	end

	gvn_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.sq       (sq_m7),
		.side_in  (side_m7),
		.root     (root),
		.side_out (side_rt)
	);

	gvn_div u_div (
		.clk      (clk),
		.en       (en),
		.root     (root),
		.side_in  (side_rt),
		.quot     (quot),
		.side_out (side_dv)
	);

	// output register: sign applied, zero on degenerate
	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= side_dv.degen;
			if (side_dv.degen) begin
				nx_q <= '0;
				ny_q <= '0;
				nz_q <= '0;
			end else begin
				nx_q <= side_dv.neg[0] ? OW'(-quot[0]) : OW'(quot[0]);
				ny_q <= side_dv.neg[1] ? OW'(-quot[1]) : OW'(quot[1]);
				nz_q <= side_dv.neg[2] ? OW'(-quot[2]) : OW'(quot[2]);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign normal_z   = nz_q;
	assign degenerate = degen_q;

endmodule

>>> rtl/core/gvn_check.sv
`include "grid_vertex_normal_top_defines.svh"

module gvn_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [gvn_pkg::OW-1:0] normal_x,
	input logic signed [gvn_pkg::OW-1:0] normal_y,
	input logic signed [gvn_pkg::OW-1:0] normal_z,
	input logic                          degenerate
);

	// stalled result stays offered and unchanged
	`GVN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`GVN_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(degenerate))

	// an empty output slot never blocks the input
	`GVN_ASSERT_NOW(a_ready_free, !out_valid, in_ready)

	// degenerate result carries a zero normal
	`GVN_ASSERT_NOW(a_degen_zero, out_valid && degenerate, normal_x == 0 && normal_y == 0 && normal_z == 0)

	// every contribution points upward, so y is never negative
	`GVN_ASSERT_NOW(a_y_up, out_valid, !normal_y[gvn_pkg::OW-1])

endmodule

bind grid_vertex_normal_top gvn_check u_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.degenerate (degenerate)
);

>>> sim/testbench.sv
module testbench;
	import gvn_pkg::*;

	localparam int LIMIT = 2000000;
	localparam int DRAIN = 80;

	// one expected normal
	typedef struct {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               degen;
	} normal_t;

	// scoreboard of expected normals
	class normal_board;
		normal_t pending[$];
		int      mismatches;

		function void note_vertex(normal_t n);
			pending = {pending, n};
		endfunction

		function void check_normal(normal_t got);
			normal_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: %0d %0d %0d %0b",
						got.nx, got.ny, got.nz, got.degen);
				return;
			end
			want = pending.pop_front();
			if (want.nx !== got.nx || want.ny !== got.ny || want.nz !== got.nz ||
					want.degen !== got.degen) begin
				mismatches++;
				if (mismatches <= 10)
					$display("normal mismatch: expected %0d %0d %0d %0b got %0d %0d %0d %0b",
						want.nx, want.ny, want.nz, want.degen,
						got.nx, got.ny, got.nz, got.degen);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [PTW-1:0] center_point, next_slice_point, before_point, prev_slice_point, after_point;
	logic out_valid;
	logic out_ready;
	logic signed [OW-1:0] normal_x, normal_y, normal_z;
	logic degenerate;
	logic cfg_wr_en;
	logic [TW-1:0] cfg_wr_data;

	normal_board board;
	logic [47:0] threshold;
	longint unsigned cycles;
	int idle_lo, idle_hi;

	grid_vertex_normal_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.center_point(center_point), .next_slice_point(next_slice_point),
		.before_point(before_point), .prev_slice_point(prev_slice_point),
		.after_point(after_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// signed coordinate of a packed point, pos 2 = x
	function automatic longint coord(logic [47:0] w, int pos);
		logic signed [15:0] c;
		c = w[pos*16 +: 16];
		return longint'(c);
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? unsigned'(-v) : unsigned'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// area-weighted normal of a vertex and its ring of four neighbors
	function automatic normal_t vertex_normal(logic [47:0] pts[5]);
		longint c[3], p[4][3], acc[3], a[3], b[3], x[3];
		longint unsigned mag[3], m, sq, t, len, q;
		bit big;
		int sh;
		normal_t n;
		for (int k = 0; k < 3; k++) begin
			c[k] = coord(pts[0], 2 - k);
			acc[k] = 0;
		end
		for (int j = 0; j < 4; j++)
			for (int k = 0; k < 3; k++)
				p[j][k] = coord(pts[j+1], 2 - k);
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 3; k++) begin
				a[k] = p[j][k] - c[k];
				b[k] = p[(j+1) % 4][k] - c[k];
			end
			x[0] = a[1]*b[2] - a[2]*b[1];
			x[1] = a[2]*b[0] - a[0]*b[2];
			x[2] = a[0]*b[1] - a[1]*b[0];
			sq = 0;
			big = 0;
			for (int k = 0; k < 3; k++) begin
				t = magnitude(x[k]);
				if (t >= (64'd1 << 24))
					big = 1;
				else
					sq += t * t;
			end
			if (big || sq > threshold) begin
				// flip so the pair points upward
				if (x[1] < 0)
					for (int k = 0; k < 3; k++)
						x[k] = -x[k];
				for (int k = 0; k < 3; k++)
					acc[k] += x[k];
			end
		end
		m = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = magnitude(acc[k]);
			if (mag[k] > m)
				m = mag[k];
		end
		if (m == 0) begin
			n.nx = 0; n.ny = 0; n.nz = 0; n.degen = 1;
			return n;
		end
		// bring the largest magnitude into [2^29, 2^30)
		sh = 0;
		if (m >= (64'd1 << 30)) begin
			while ((m >> sh) >= (64'd1 << 30))
				sh++;
			for (int k = 0; k < 3; k++)
				mag[k] >>= sh;
		end else begin
			while ((m << sh) < (64'd1 << 29))
				sh++;
			for (int k = 0; k < 3; k++)
				mag[k] <<= sh;
		end
		len = int_sqrt(mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2]);
		for (int k = 0; k < 3; k++) begin
			q = ((mag[k] << 14) + (len >> 1)) / len;
			if (acc[k] < 0)
				q = -q;
			if (k == 0) n.nx = q[15:0];
			else if (k == 1) n.ny = q[15:0];
			else n.nz = q[15:0];
		end
		n.degen = 0;
		return n;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (idle_hi == 0)
			return 0;
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(idle_lo, idle_hi);
	endfunction

	// valid stays up across back-to-back transactions and drops only for a gap
	task automatic send_vertex(logic [47:0] pts[5]);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g)
				@(posedge clk);
		end
		in_valid <= 1;
		center_point <= pts[0];
		next_slice_point <= pts[1];
		before_point <= pts[2];
		prev_slice_point <= pts[3];
		after_point <= pts[4];
		board.note_vertex(vertex_normal(pts));
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		if (in_valid)
			in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(logic [47:0] v);
		wait_drained();
		repeat (DRAIN)
			@(posedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		threshold = v;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	function automatic logic [47:0] pack(int x, int y, int z);
		return {16'(x), 16'(y), 16'(z)};
	endfunction

	// small or wide offset from the center, a random point, or center itself (absent neighbor)
	function automatic logic [47:0] neighbor(logic [47:0] ctr);
		int r;
		logic [15:0] d[3];
		r = $urandom_range(0, 99);
		if (r < 12)
			return ctr;
		if (r < 25)
			return 48'($urandom());
		for (int k = 0; k < 3; k++) begin
			d[k] = (r < 70) ? 16'($urandom_range(0, 64) - 32) : 16'($urandom_range(0, 4096) - 2048);
			d[k] = ctr[(2-k)*16 +: 16] + d[k];
		end
		return pack(d[0], d[1], d[2]);
	endfunction

	task automatic random_vertices(int count);
		logic [47:0] pts[5];
		for (int i = 0; i < count; i++) begin
			pts[0] = 48'({$urandom(), $urandom()});
			if ($urandom_range(0, 9) == 0) begin
				for (int j = 1; j < 5; j++)
					pts[j] = 48'({$urandom(), $urandom()});
			end else begin
				for (int j = 1; j < 5; j++)
					pts[j] = neighbor(pts[0]);
			end
			send_vertex(pts);
		end
	endtask

	// output side: random stalls, check every accepted transaction
	initial begin
		normal_t got;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.nx = normal_x; got.ny = normal_y; got.nz = normal_z;
				got.degen = degenerate;
				board.check_normal(got);
			end
			out_ready <= (gap_len() == 0);
		end
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("grid_vertex_normal_top test failed");
				$finish;
			end
		end
	end

	initial begin
		logic [47:0] pts[5];
		logic [47:0] ctr;
		board = new();
		threshold = 0;
		idle_lo = 4; idle_hi = 30;
		arst_n = 0;
		in_valid = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		center_point = 0; next_slice_point = 0; before_point = 0;
		prev_slice_point = 0; after_point = 0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: all absent, flat grid, extremes, downward pairs
		ctr = pack(16'h0100, 16'h0020, 16'hff00);
		pts = '{ctr, ctr, ctr, ctr, ctr};
		send_vertex(pts);
		pts = '{pack(0, 0, 0), pack(16, 0, 0), pack(0, 0, 16), pack(-16, 0, 0), pack(0, 0, -16)};
		send_vertex(pts);
		pts = '{pack(0, 0, 0), pack(0, 0, 16), pack(16, 0, 0), pack(0, 0, -16), pack(-16, 0, 0)};
		send_vertex(pts);
		pts = '{pack(0, 0, 0), pack(16, 3, 0), pack(0, 0, 16), ctr, ctr};
		send_vertex(pts);
		pts = '{pack(16'h8000, 16'h8000, 16'h8000), pack(16'h7fff, 16'h7fff, 16'h8000),
			pack(16'h8000, 16'h7fff, 16'h7fff), pack(16'h7fff, 16'h8000, 16'h7fff),
			pack(16'h8000, 16'h8000, 16'h7fff)};
		send_vertex(pts);
		pts = '{48'hffffffffffff, 48'h0, 48'hffffffffffff, 48'h7fff7fff7fff, 48'h800080008000};
		send_vertex(pts);
		pts = '{pack(0, 0, 0), pack(1, 0, 0), pack(0, 0, 1), pack(-1, 0, 0), pack(0, 0, -1)};
		send_vertex(pts);
		pts = '{pack(5, 5, 5), pack(5, 5, 5), pack(6, 5, 5), pack(5, 5, 5), pack(5, 5, 6)};
		send_vertex(pts);
		pts = '{pack(0, 0, 0), pack(16, 0, 0), pack(0, 16, 0), pack(-16, 0, 0), pack(0, -16, 0)};
		send_vertex(pts);
		random_vertices(10);

		// threshold settings, maximum among them
		write_threshold(48'hffffffffffff);
		pts = '{pack(0, 0, 0), pack(1, 0, 0), pack(0, 0, 1), pack(-1, 0, 0), pack(0, 0, -1)};
		send_vertex(pts);
		random_vertices(150);
		write_threshold(48'd1);
		send_vertex(pts);
		random_vertices(150);
		write_threshold(48'd1 << 20);
		random_vertices(300);

		// sender pauses until all normals are back
		wait_drained();
		write_threshold(48'd0);
		idle_hi = 0;
		random_vertices(300);
		idle_hi = 30;
		write_threshold(48'($urandom_range(0, 1 << 30)));
		random_vertices(500);
		write_threshold(48'({$urandom(), $urandom()}));
		random_vertices(300);

		wait_drained();
		repeat (DRAIN)
			@(posedge clk);
		if (board.mismatches == 0)
			$display("grid_vertex_normal_top test passed");
		else
			$display("grid_vertex_normal_top test failed");
		$finish;
	end

endmodule
